/* hdl/swmd_pkg.sv */
// swmd_pkg: shared types and constants for the sliding window maximum block.
// Used by swmd_cell and sliding_window_max_deque; depends on nothing.
package swmd_pkg;

   localparam int CfgBits = 7;
   localparam logic [CfgBits-1:0] WINDOW_RESET = 7'd3;

   // per-word control broadcast to every cell
   typedef struct packed {
      logic load;
      logic start;
      logic emit;
   } step_type;

endpackage

/* hdl/swmd_cell.sv */
// swmd_cell: one slot of the sample shift chain with its candidate flag.
// Depends on swmd_pkg (step_type).
module swmd_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int WIN_BITS    = 7,
   parameter int INDEX       = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  swmd_pkg::step_type     step,
   input  logic [WIN_BITS-1:0]    win,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [SAMPLE_BITS-1:0] prev_val,
   input  logic                   prev_live,
   output logic [SAMPLE_BITS-1:0] val_q,
   output logic                   vld_q,
   output logic                   live
);

   logic [SAMPLE_BITS-1:0] val_ff;
   logic                   vld_ff;
   logic                   vld_in;
   logic                   too_old;

   // age of the slot after the shift equals its index
   assign too_old = step.emit && (WIN_BITS'(INDEX) >= win);
   assign vld_in  = prev_live && !too_old;

   // survives the new word: not cleared and strictly greater than it
   assign live = vld_ff && !step.start && ($signed(val_ff) > $signed(sample));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (step.load) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step.load) begin
         val_ff <= prev_val;
      end
   end

   assign val_q = val_ff;
   assign vld_q = vld_ff;

endmodule

/* hdl/swmd_max_tree.sv */
// swmd_max_tree: pipelined maximum over the valid cells, a register every
// three levels, with per-stage ready. Depends on nothing.
module swmd_max_tree #(
   parameter int LEAVES      = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [LEAVES-1:0]                  leaf_vld,
   input  logic [LEAVES-1:0][SAMPLE_BITS-1:0] leaf_val,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [SAMPLE_BITS-1:0]             out_val
);

   localparam int Levels   = $clog2(LEAVES);
   localparam int Stages   = (Levels + 2) / 3;
   localparam int Internal = (1 << Levels) - 1;
   localparam int Nodes    = 2 * Internal + 1;

   logic [SAMPLE_BITS:0] node_q  [Nodes];
   logic [SAMPLE_BITS:0] comb_q  [Internal];
   logic [Stages-1:0]    stg_vld_ff;
   logic [Stages:0]      rdy;

   function automatic logic [SAMPLE_BITS:0] pick(input logic [SAMPLE_BITS:0] a,
                                                 input logic [SAMPLE_BITS:0] b);
      logic take_a;
      take_a = a[SAMPLE_BITS] &&
               (!b[SAMPLE_BITS] ||
                ($signed(a[SAMPLE_BITS-1:0]) >= $signed(b[SAMPLE_BITS-1:0])));
      return take_a ? a : b;
   endfunction

   assign rdy[Stages] = out_ready;

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      assign rdy[k] = !stg_vld_ff[k] || rdy[k+1];

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_vld_ff[k] <= 1'b0;
         end else if (rdy[k]) begin
            stg_vld_ff[k] <= (k == 0) ? in_valid : stg_vld_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   for (genvar j = 0; j < (1 << Levels); j++) begin : g_leaf
      if (j < LEAVES) begin : g_used
         assign node_q[Internal+j] = {leaf_vld[j], leaf_val[j]};
      end else begin : g_pad
         assign node_q[Internal+j] = '0;
      end
   end

   for (genvar n = 0; n < Internal; n++) begin : g_node
      localparam int Depth  = $clog2(n + 2) - 1;
      localparam int Height = Levels - Depth;
      localparam int Stg    = (Height + 2) / 3 - 1;

      assign comb_q[n] = pick(node_q[2*n+1], node_q[2*n+2]);

      if ((Height % 3 == 0) || (Depth == 0)) begin : g_reg
         logic [SAMPLE_BITS:0] node_ff;

         always_ff @(posedge clock) begin
            if (rdy[Stg]) begin
               node_ff <= comb_q[n];
            end
         end
         assign node_q[n] = node_ff;
      end else begin : g_comb
         assign node_q[n] = comb_q[n];
      end
   end

   assign in_ready  = rdy[0];
   assign out_valid = stg_vld_ff[Stages-1];
   assign out_val   = node_q[0][SAMPLE_BITS-1:0];

endmodule

/* hdl/sliding_window_max_deque.sv */
// sliding_window_max_deque: running maximum over the last window_size samples.
// Depends on swmd_pkg, swmd_cell and swmd_max_tree.
//
// One sample word is accepted per clock, unless a result still waits for the
// stalled max tree. Each word enters a chain of WINDOW_MAX cells that shifts
// by one slot per word, so a cell's index is the age of the sample it holds;
// a parallel compare across all cells drops older samples that are not larger
// than the new one, and on a word that completes a window the cells at or
// beyond the window are dropped too. The maximum of the surviving cells goes
// through a max tree registered every three levels. No result word is
// produced until window_size samples of the current sequence have arrived;
// req_tuser high restarts the sequence. csr_wdata of 0 acts as 1, above
// WINDOW_MAX as WINDOW_MAX.
module sliding_window_max_deque #(
   parameter int WINDOW_MAX  = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [swmd_pkg::CfgBits-1:0]           csr_wdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // [SAMPLE_BITS-1:0] sample, zero padded to whole bytes
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       req_tdata,
   // [0] start_req
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // [SAMPLE_BITS-1:0] window_max, zero padded to whole bytes
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]       rsp_tdata
);

   localparam int DataBits = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int WinBits  = $clog2(WINDOW_MAX + 1);
   localparam int ExtBits  = (WinBits > swmd_pkg::CfgBits) ? WinBits : swmd_pkg::CfgBits;

   logic [swmd_pkg::CfgBits-1:0]         cfg_ff;
   logic [ExtBits-1:0]                   cfg_ext;
   logic [ExtBits-1:0]                   win_ext;
   logic [WinBits-1:0]                   win;
   logic [WinBits-1:0]                   fill_ff;
   logic [WinBits-1:0]                   fill_in;
   logic [WinBits-1:0]                   fill_base;
   logic                                 pend_ff;
   logic                                 pend_in;
   logic                                 accept;
   logic                                 emit;
   logic                                 tree_ready;
   logic [SAMPLE_BITS-1:0]               sample;
   logic [SAMPLE_BITS-1:0]               out_val;
   swmd_pkg::step_type                   step;

   logic [SAMPLE_BITS-1:0]               cell_val  [WINDOW_MAX];
   logic                                 cell_live [WINDOW_MAX];
   logic [WINDOW_MAX-1:0]                leaf_vld;
   logic [WINDOW_MAX-1:0][SAMPLE_BITS-1:0] leaf_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= swmd_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         cfg_ff <= csr_wdata;
      end
   end

   assign cfg_ext = ExtBits'(cfg_ff);

   always_comb begin
      priority if (cfg_ext == '0) begin
         win_ext = ExtBits'(1);
      end else if (cfg_ext > ExtBits'(WINDOW_MAX)) begin
         win_ext = ExtBits'(WINDOW_MAX);
      end else begin
         win_ext = cfg_ext;
      end
   end

   assign win = win_ext[WinBits-1:0];

   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign req_tready = !pend_ff || tree_ready;
   assign accept     = req_tvalid && req_tready;

   assign fill_base = req_tuser ? '0 : fill_ff;
   assign fill_in   = (fill_base < win) ? fill_base + WinBits'(1) : win;
   assign emit      = (fill_in == win);

   always_comb begin
      priority if (accept) begin
         pend_in = emit;
      end else if (tree_ready) begin
         pend_in = 1'b0;
      end else begin
         pend_in = pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

   assign step.load  = accept;
   assign step.start = req_tuser;
   assign step.emit  = emit;

   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      logic [SAMPLE_BITS-1:0] prev_val;
      logic                   prev_live;
      logic                   vld_q;

      if (i == 0) begin : g_head
         assign prev_val  = sample;
         assign prev_live = 1'b1;
      end else begin : g_body
         assign prev_val  = cell_val[(i == 0) ? 0 : i-1];
         assign prev_live = cell_live[(i == 0) ? 0 : i-1];
      end

      swmd_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .WIN_BITS    (WinBits),
         .INDEX       (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .win       (win),
         .sample    (sample),
         .prev_val  (prev_val),
         .prev_live (prev_live),
         .val_q     (cell_val[i]),
         .vld_q     (vld_q),
         .live      (cell_live[i])
      );

      assign leaf_vld[i] = vld_q;
      assign leaf_val[i] = cell_val[i];
   end

   swmd_max_tree #(
      .LEAVES      (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_tree (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pend_ff),
      .in_ready  (tree_ready),
      .leaf_vld  (leaf_vld),
      .leaf_val  (leaf_val),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_val   (out_val)
   );

   assign rsp_tdata = DataBits'(out_val);

   // newest sample is always a candidate
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      accept |=> leaf_vld[0])
      else $error("head cell not valid after a word");

   a_restart_fill: assert property (@(posedge clock) disable iff (reset)
      accept && req_tuser |=> fill_ff == WinBits'(1))
      else $error("fill count wrong after restart");

   a_pend_emit: assert property (@(posedge clock) disable iff (reset)
      accept |=> pend_ff == $past(emit))
      else $error("result flag does not follow window fill");

   a_stall_pend: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> pend_ff && !tree_ready)
      else $error("input stalled without a pending result");

endmodule

/* tb/swmd_window_checker.sv */
// swmd_window_checker: watches the sample and maximum channels of
// sliding_window_max_deque, predicts each window maximum and compares.
// Depends on swmd_pkg for the register width and reset value.
`timescale 1ns / 100ps

module swmd_window_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [swmd_pkg::CfgBits-1:0] csr_wdata,
   input  logic                         req_tvalid,
   input  logic                         req_tready,
   input  logic [15:0]                  req_tdata,
   input  logic                         req_tuser,
   input  logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   input  logic [15:0]                  rsp_tdata,
   output int                           fail_count,
   output int                           pending_words
);

   localparam int WinMax    = 64;
   localparam int PosMod    = 2 * WinMax;
   localparam int WantDepth = 64;

   logic signed [15:0]           cand_value [0:WinMax-1];
   int                           cand_pos   [0:WinMax-1];
   int                           cand_count;
   int                           pos_ctr;
   int                           fill_ctr;
   logic [swmd_pkg::CfgBits-1:0] window_reg;
   logic [15:0]                  want_buf [0:WantDepth-1];
   int                           want_rd;
   int                           want_wr;

   task automatic pop_oldest_candidate();
      if (cand_count > 0) begin
         for (int i = 0; i < cand_count - 1; i++) begin
            cand_value[i] = cand_value[i+1];
            cand_pos[i]   = cand_pos[i+1];
         end
         cand_count--;
      end
   endtask

   task automatic push_sample(input logic signed [15:0] s, input logic restart,
                              output bit produced, output logic [15:0] max_out);
      int w;
      int p;
      w = (window_reg == 0) ? 1 : ((window_reg > WinMax) ? WinMax : int'(window_reg));
      if (restart) begin
         cand_count = 0;
         pos_ctr    = 0;
         fill_ctr   = 0;
      end
      p = pos_ctr % PosMod;
      while (cand_count > 0 && cand_value[cand_count-1] <= s)
         cand_count--;
      if (cand_count >= WinMax)
         pop_oldest_candidate();
      cand_value[cand_count] = s;
      cand_pos[cand_count]   = p;
      cand_count++;
      pos_ctr  = (p + 1) % PosMod;
      fill_ctr = (fill_ctr < w) ? fill_ctr + 1 : w;
      produced = 0;
      max_out  = '0;
      if (fill_ctr >= w) begin
         while (cand_count > 0 && ((p + PosMod - cand_pos[0]) % PosMod) >= w)
            pop_oldest_candidate();
         max_out  = (cand_count > 0) ? cand_value[0] : s;
         produced = 1;
      end
   endtask

   always @(posedge clock) begin : watch
      bit          produced;
      logic [15:0] max_val;
      logic [15:0] want;
      if (reset) begin
         cand_count = 0;
         pos_ctr    = 0;
         fill_ctr   = 0;
         window_reg = swmd_pkg::WINDOW_RESET;
         want_rd    = 0;
         want_wr    = 0;
         fail_count = 0;
      end else begin
         if ($isunknown({req_tready, rsp_tvalid})) begin
            fail_count++;
            $display("%0t: handshake unknown, expected 0/1, actual ready=%b valid=%b",
                     $time, req_tready, rsp_tvalid);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (want_wr == want_rd) begin
               fail_count++;
               $display("%0t: unexpected max word, expected none, actual %0d",
                        $time, $signed(rsp_tdata));
            end else begin
               want = want_buf[want_rd % WantDepth];
               want_rd++;
               if (rsp_tdata !== want) begin
                  fail_count++;
                  $display("%0t: window_max mismatch, expected %0d, actual %0d",
                           $time, $signed(want), $signed(rsp_tdata));
               end
            end
         end
         if (csr_we)
            window_reg = csr_wdata;
         if (req_tvalid && req_tready) begin
            push_sample(req_tdata, req_tuser, produced, max_val);
            if (produced) begin
               if (want_wr - want_rd >= WantDepth) begin
                  fail_count++;
                  $display("%0t: max words backed up, expected below %0d, actual %0d",
                           $time, WantDepth, want_wr - want_rd);
               end
               want_buf[want_wr % WantDepth] = max_val;
               want_wr++;
            end
         end
      end
      pending_words = want_wr - want_rd;
   end

endmodule

/* tb/tb_sliding_window_max_deque.sv */
// tb_sliding_window_max_deque: stimulus and verdict for sliding_window_max_deque.
// Drives bursty sample words and a stalling receiver; swmd_window_checker
// predicts and compares. Depends on swmd_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_sliding_window_max_deque;

   typedef enum int {SHAPE_RANDOM, SHAPE_NARROW, SHAPE_RISING, SHAPE_FALLING} run_shape_type;

   logic                         clock;
   logic                         reset;
   logic                         csr_we;
   logic [swmd_pkg::CfgBits-1:0] csr_wdata;
   logic                         req_tvalid;
   logic                         req_tready;
   logic [15:0]                  req_tdata;
   logic                         req_tuser;
   logic                         rsp_tvalid;
   logic                         rsp_tready;
   logic [15:0]                  rsp_tdata;
   int                           fail_count;
   int                           pending_words;

   int rx_ready_pct  = 100;
   int hold_off_req   = 0;
   bit sender_steady  = 1;
   int burst_left     = 0;

   int dir_sample [0:21];
   bit dir_start  [0:21];

   sliding_window_max_deque i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   swmd_window_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_words (pending_words)
   );

   initial clock = 0;
   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   initial begin
      #400000;
      $display("FAIL");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin : receiver
      int hold_done;
      hold_done  = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req != hold_done) begin
            hold_done  = hold_off_req;
            rsp_tready = 0;
            repeat (300) @(negedge clock);
         end else begin
            rsp_tready = ($urandom_range(0, 99) < rx_ready_pct);
         end
      end
   end

   task automatic send_word(input logic [15:0] s, input bit restart);
      int gap;
      if (!sender_steady && burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid = 0;
            req_tdata  = 16'($urandom);
            req_tuser  = 1'($urandom);
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0)
         burst_left--;
      @(negedge clock);
      req_tvalid = 1;
      req_tdata  = s;
      req_tuser  = restart;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_run(input int len, input run_shape_type shape, input bit restart);
      int base;
      int step;
      int v;
      bit st;
      base = 0;
      step = 0;
      if (shape == SHAPE_RISING) begin
         base = -32768 + $urandom_range(0, 8000);
         step = $urandom_range(0, 300);
      end else if (shape == SHAPE_FALLING) begin
         base = 32767 - $urandom_range(0, 8000);
         step = $urandom_range(1, 300);
      end
      for (int i = 0; i < len; i++) begin
         case (shape)
            SHAPE_NARROW:  v = $urandom_range(0, 3) - 2;
            SHAPE_RISING:  v = base + i * step;
            SHAPE_FALLING: v = base - i * step;
            default:       v = $urandom;
         endcase
         st = (i == 0) ? restart : ($urandom_range(0, 39) == 0);
         send_word(16'(v), st);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 0;
      while (pending_words != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic run_phase(input logic [swmd_pkg::CfgBits-1:0] win, input int items,
                            input int ready_pct, input bit steady, input bit hold);
      int eff;
      int sent;
      int len;
      drain_results();
      @(negedge clock);
      csr_we    = 1;
      csr_wdata = win;
      @(negedge clock);
      csr_we    = 0;
      rx_ready_pct  = ready_pct;
      sender_steady = steady;
      burst_left    = 0;
      if (hold)
         hold_off_req++;
      eff  = (win == 0) ? 1 : ((win > 64) ? 64 : int'(win));
      sent = 0;
      while (sent < items) begin
         len = $urandom_range(1, 2 * eff + 4);
         if (len > items - sent)
            len = items - sent;
         send_run(len, run_shape_type'($urandom_range(0, 3)), $urandom_range(0, 7) != 0);
         sent += len;
      end
   endtask

   initial begin
      reset      = 1;
      csr_we     = 0;
      csr_wdata  = '0;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tuser  = 0;
      dir_sample = '{32767, -32768, -32768, 0, -1, 1, 1, 1, -32768, 32767, 5,
                     5, 5, 4, 3, 2, 1, -2, 7, -32768, -32768, -32768};
      dir_start  = '{1, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1,
                     0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      repeat (12) @(negedge clock);
      reset = 0;

      // reset window of three: extremes, ties, restarts before and after fill
      sender_steady = 0;
      rx_ready_pct  = 100;
      for (int i = 0; i < 22; i++)
         send_word(16'(dir_sample[i]), dir_start[i]);

      run_phase(7'd1, 30, 70, 0, 0);
      // full candidate list and position wrap: a long falling run, then a random run
      run_phase(7'd64, 0, 100, 1, 0);
      send_run(70, SHAPE_FALLING, 1);
      send_run(80, SHAPE_RANDOM, 0);
      run_phase(7'd0, 25, 50, 0, 0);
      run_phase(7'd2, 40, 100, 1, 1);
      run_phase(7'd127, 60, 80, 0, 0);
      run_phase(7'd5, 40, 25, 0, 0);
      run_phase(7'd100, 30, 60, 1, 0);
      run_phase(7'd17, 40, 90, 0, 0);
      run_phase(7'($urandom_range(1, 64)), 40, 50, 0, 0);
      drain_results();

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/swmd_pkg.sv
hdl/swmd_cell.sv
hdl/swmd_max_tree.sv
hdl/sliding_window_max_deque.sv
tb/swmd_window_checker.sv
tb/tb_sliding_window_max_deque.sv
